[src/ptmb_pkg.sv]
// Shared types and constants for the page table map builder.
package ptmb_pkg;

   localparam int TABLE_SLOTS       = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int SLOT_W            = $clog2(TABLE_SLOTS);
   localparam int SLOTS_CNT_W       = $clog2(TABLE_SLOTS + 1);
   localparam int IDX_W             = 9;
   localparam int ADDR_W            = SLOT_W + IDX_W;
   localparam int ENTRY_W           = 64 + SLOT_W;
   localparam int PA_W              = 52;
   localparam int VA_W              = 48;

   localparam logic [1:0] LVL_PML4 = 2'd0;
   localparam logic [1:0] LVL_PDPT = 2'd1;
   localparam logic [1:0] LVL_PD   = 2'd2;
   localparam logic [1:0] LVL_PT   = 2'd3;

   localparam logic [63:0] FLAGS_LINK  = 64'h3;
   localparam logic [63:0] FLAGS_LEAF  = 64'h3;
   localparam logic [63:0] FLAGS_LARGE = 64'h83;

   localparam logic [4:0] CSR_ROOT_ADDR  = 5'd0;
   localparam logic [4:0] CSR_POOL_BASE  = 5'd8;
   localparam logic [4:0] CSR_POOL_BYTES = 5'd16;
   localparam logic [31:0] POOL_BYTES_RST = 32'd262144;

   typedef enum logic [1:0] {
      FN_MAP_4K = 2'd0,
      FN_MAP_2M = 2'd1,
      FN_READ   = 2'd2,
      FN_NOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOMEM = 2'd1,
      ST_LARGE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_INIT_CLR,
      S_IDLE,
      S_PAGE,
      S_LOOKUP,
      S_EVAL,
      S_ALIGN,
      S_ACHK,
      S_LINK,
      S_CLEAR,
      S_LEAF,
      S_RDISSUE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic lookup;
      logic descend;
      logic align;
      logic commit;
      logic link_wr;
      logic clr_wr;
      logic leaf_wr;
      logic page_next;
      logic set_nomem;
      logic set_large;
      logic rd_word;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     present;
      logic     bad;
      logic     alloc_fail;
      logic     clr_last;
      logic     pages_left;
      logic     next_is_leaf;
      logic     at_leaf;
   } sts_type;

endpackage

[src/page_table_map_builder_unit.sv]
// Top level of the page table map builder: configuration registers and wiring.
//
// Builds four-level x86-64 page tables in an internal store of 64 tables of 512
// 64-bit entries, one request at a time. After reset the root table is cleared
// before the first request is taken. A map request for 4 KiB or 2 MiB pages
// takes, for each page, a read and a check at each table level, then the leaf
// write; each new table it needs is allocated, linked and then cleared by a
// sweep that writes one entry a cycle. Status 1 reports an exhausted heap or
// table store and status 2 a large page or foreign entry met where a table was
// expected; pages mapped before the stop stay mapped.
module page_table_map_builder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [47:0] req_virt_base,
   input  logic [51:0] req_phys_base,
   input  logic [15:0] req_page_count,
   input  logic [5:0]  req_read_slot,
   input  logic [8:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_pages_done,
   output logic [6:0]  rsp_tables_in_use,
   output logic [31:0] rsp_heap_used,
   output logic [63:0] rsp_read_word,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import ptmb_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [51:0] root_addr_ff;
   logic [51:0] pool_base_ff;
   logic [31:0] pool_bytes_ff;
   logic        csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_addr_ff  <= '0;
         pool_base_ff  <= '0;
         pool_bytes_ff <= POOL_BYTES_RST;
      end else if (csr_wr) begin
         case (csr_paddr)
            CSR_ROOT_ADDR:  root_addr_ff  <= csr_pwdata[51:0];
            CSR_POOL_BASE:  pool_base_ff  <= csr_pwdata[51:0];
            CSR_POOL_BYTES: pool_bytes_ff <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         CSR_ROOT_ADDR:  csr_prdata = {12'b0, root_addr_ff};
         CSR_POOL_BASE:  csr_prdata = {12'b0, pool_base_ff};
         CSR_POOL_BYTES: csr_prdata = {32'b0, pool_bytes_ff};
         default:        csr_prdata = '0;
      endcase
   end

   ptmb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ptmb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_func          (req_func),
      .req_virt_base     (req_virt_base),
      .req_phys_base     (req_phys_base),
      .req_page_count    (req_page_count),
      .req_read_slot     (req_read_slot),
      .req_read_index    (req_read_index),
      .pool_base         (pool_base_ff),
      .pool_bytes        (pool_bytes_ff),
      .rsp_status        (rsp_status),
      .rsp_pages_done    (rsp_pages_done),
      .rsp_tables_in_use (rsp_tables_in_use),
      .rsp_heap_used     (rsp_heap_used),
      .rsp_read_word     (rsp_read_word)
   );

endmodule

[src/ptmb_datapath.sv]
// Datapath of the page table map builder: table store, allocator, walk registers.
module ptmb_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  ptmb_pkg::cmd_type            cmd,
   output ptmb_pkg::sts_type            sts,
   input  logic [1:0]                   req_func,
   input  logic [47:0]                  req_virt_base,
   input  logic [51:0]                  req_phys_base,
   input  logic [15:0]                  req_page_count,
   input  logic [5:0]                   req_read_slot,
   input  logic [8:0]                   req_read_index,
   input  logic [51:0]                  pool_base,
   input  logic [31:0]                  pool_bytes,
   output logic [1:0]                   rsp_status,
   output logic [15:0]                  rsp_pages_done,
   output logic [6:0]                   rsp_tables_in_use,
   output logic [31:0]                  rsp_heap_used,
   output logic [63:0]                  rsp_read_word
);
   import ptmb_pkg::*;

   logic [ENTRY_W-1:0] mem [TABLE_SLOTS*ENTRIES_PER_TABLE];
   logic [ENTRY_W-1:0] rdata_ff;

   func_type             func_ff;
   logic [VA_W-1:0]      va_ff;
   logic [PA_W-1:0]      pa_ff;
   logic [15:0]          count_ff;
   logic [15:0]          done_ff;
   logic [5:0]           rslot_ff;
   logic [IDX_W-1:0]     ridx_ff;
   status_type           status_ff;
   logic [1:0]           lvl_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [SLOT_W-1:0]    new_slot_ff;
   logic [IDX_W-1:0]     clr_idx_ff;
   logic [SLOTS_CNT_W-1:0] slots_used_ff;
   logic [31:0]          alloc_offset_ff;
   logic [52:0]          aligned_ff;

   logic [IDX_W-1:0]     lvl_idx;
   logic                 big;
   logic [52:0]          cur_sum;
   logic [53:0]          next_off;
   logic [SLOT_W-1:0]    tag;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   logic                 rd_en;
   logic [ADDR_W-1:0]    rd_addr;
   logic [PA_W-1:0]      pa_step;
   logic [VA_W-1:0]      va_step;
   logic                 slot_live;

   assign big = (func_ff == FN_MAP_2M);
   assign tag = rdata_ff[ENTRY_W-1:64];

   always_comb begin
      case (lvl_ff)
         LVL_PML4: lvl_idx = va_ff[47:39];
         LVL_PDPT: lvl_idx = va_ff[38:30];
         LVL_PD:   lvl_idx = va_ff[29:21];
         default:  lvl_idx = va_ff[20:12];
      endcase
   end

   assign cur_sum  = {1'b0, pool_base} + {21'b0, alloc_offset_ff} + 53'hFFF;
   assign next_off = {1'b0, aligned_ff} - {2'b0, pool_base} + 54'd4096;
   assign pa_step  = big ? PA_W'(32'h200000) : PA_W'(32'h1000);
   assign va_step  = big ? VA_W'(32'h200000) : VA_W'(32'h1000);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {slot_ff, lvl_idx};
      wr_data = '0;
      if (cmd.link_wr) begin
         wr_en   = 1'b1;
         wr_data = {new_slot_ff, 12'b0, aligned_ff[51:0] | FLAGS_LINK[51:0]};
      end else if (cmd.clr_wr) begin
         wr_en   = 1'b1;
         wr_addr = {slot_ff, clr_idx_ff};
      end else if (cmd.leaf_wr) begin
         wr_en   = 1'b1;
         wr_data = {{SLOT_W{1'b0}}, {12'b0, pa_ff} | (big ? FLAGS_LARGE : FLAGS_LEAF)};
      end
   end

   assign rd_en   = cmd.lookup | cmd.rd_word;
   assign rd_addr = cmd.rd_word ? {SLOT_W'(rslot_ff), ridx_ff} : {slot_ff, lvl_idx};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff          <= LVL_PML4;
         slot_ff         <= '0;
         clr_idx_ff      <= '0;
         slots_used_ff   <= SLOTS_CNT_W'(1);
         alloc_offset_ff <= '0;
         status_ff       <= ST_OK;
         done_ff         <= '0;
      end else begin
         if (cmd.load) begin
            lvl_ff    <= LVL_PML4;
            slot_ff   <= '0;
            status_ff <= ST_OK;
            done_ff   <= '0;
         end
         if (cmd.descend) begin
            slot_ff <= tag;
            lvl_ff  <= lvl_ff + 2'd1;
         end
         if (cmd.commit) begin
            alloc_offset_ff <= next_off[31:0];
            new_slot_ff     <= slots_used_ff[SLOT_W-1:0];
            slots_used_ff   <= slots_used_ff + SLOTS_CNT_W'(1);
         end
         if (cmd.link_wr) begin
            slot_ff    <= new_slot_ff;
            lvl_ff     <= lvl_ff + 2'd1;
            clr_idx_ff <= '0;
         end
         if (cmd.clr_wr) begin
            clr_idx_ff <= clr_idx_ff + IDX_W'(1);
         end
         if (cmd.page_next) begin
            lvl_ff  <= LVL_PML4;
            slot_ff <= '0;
            done_ff <= done_ff + 16'd1;
         end
         if (cmd.set_nomem) begin
            status_ff <= ST_NOMEM;
         end
         if (cmd.set_large) begin
            status_ff <= ST_LARGE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= func_type'(req_func);
         va_ff    <= req_virt_base;
         pa_ff    <= req_phys_base;
         count_ff <= req_page_count;
         rslot_ff <= req_read_slot;
         ridx_ff  <= req_read_index;
      end
      if (cmd.page_next) begin
         va_ff <= va_ff + va_step;
         pa_ff <= pa_ff + pa_step;
      end
      if (cmd.align) begin
         aligned_ff <= {cur_sum[52:12], 12'b0};
      end
   end

   assign slot_live = ({{(SLOTS_CNT_W > 6 ? SLOTS_CNT_W - 6 : 0){1'b0}}, rslot_ff}
                       < slots_used_ff);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status        <= status_ff;
         rsp_pages_done    <= done_ff;
         rsp_tables_in_use <= 7'(slots_used_ff);
         rsp_heap_used     <= alloc_offset_ff;
         rsp_read_word     <= (func_ff == FN_READ && slot_live) ? rdata_ff[63:0] : 64'd0;
      end
   end

   always_comb begin
      sts.func         = func_ff;
      sts.present      = rdata_ff[0];
      sts.bad          = rdata_ff[7] | (tag == '0);
      sts.alloc_fail   = (next_off >= {22'b0, pool_bytes})
                         || (slots_used_ff >= SLOTS_CNT_W'(TABLE_SLOTS));
      sts.clr_last     = (clr_idx_ff == IDX_W'(ENTRIES_PER_TABLE - 1));
      sts.pages_left   = (done_ff != count_ff);
      sts.next_is_leaf = big ? (lvl_ff == LVL_PDPT) : (lvl_ff == LVL_PD);
      sts.at_leaf      = big ? (lvl_ff == LVL_PD) : (lvl_ff == LVL_PT);
   end

endmodule

[src/ptmb_ctrl.sv]
// Controller state machine of the page table map builder.
module ptmb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ptmb_pkg::cmd_type cmd,
   input  ptmb_pkg::sts_type sts
);
   import ptmb_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT_CLR: if (sts.clr_last) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) state_in = S_PAGE;
         end
         S_PAGE: begin
            case (sts.func)
               FN_MAP_4K, FN_MAP_2M: state_in = sts.pages_left ? S_LOOKUP : S_DONE;
               FN_READ:              state_in = S_RDISSUE;
               default:              state_in = S_DONE;
            endcase
         end
         S_LOOKUP: state_in = S_EVAL;
         S_EVAL: begin
            if (!sts.present) state_in = S_ALIGN;
            else if (sts.bad) state_in = S_DONE;
            else state_in = sts.next_is_leaf ? S_LEAF : S_LOOKUP;
         end
         S_ALIGN: state_in = S_ACHK;
         S_ACHK:  state_in = sts.alloc_fail ? S_DONE : S_LINK;
         S_LINK:  state_in = S_CLEAR;
         S_CLEAR: begin
            if (sts.clr_last) state_in = sts.at_leaf ? S_LEAF : S_LOOKUP;
         end
         S_LEAF:    state_in = S_PAGE;
         S_RDISSUE: state_in = S_DONE;
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_INIT_CLR: cmd.clr_wr = 1'b1;
         S_IDLE:     cmd.load = req_valid;
         S_LOOKUP:   cmd.lookup = 1'b1;
         S_EVAL: begin
            cmd.set_large = sts.present && sts.bad;
            cmd.descend   = sts.present && !sts.bad;
         end
         S_ALIGN: cmd.align = 1'b1;
         S_ACHK: begin
            cmd.set_nomem = sts.alloc_fail;
            cmd.commit    = !sts.alloc_fail;
         end
         S_LINK:    cmd.link_wr = 1'b1;
         S_CLEAR:   cmd.clr_wr = 1'b1;
         S_LEAF: begin
            cmd.leaf_wr   = 1'b1;
            cmd.page_next = 1'b1;
         end
         S_RDISSUE: cmd.rd_word = 1'b1;
         S_DONE:    cmd.rsp_load = out_free;
         default:   cmd = '0;
      endcase
   end

   // hold the result until the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
